[src/qrmm_pkg.sv]
// ----------------------------------------------------------------------------
// qrmm_pkg
// Shared types and constants for the quad rotor motor mixer: number formats,
// channel codes, register indexes and the multiplier request.
// ----------------------------------------------------------------------------
package qrmm_pkg;

  // Field widths
  localparam int unsigned LEVEL_W  = 15;  // Q7.8 percent
  localparam int unsigned GAIN_W   = 12;  // Q4.8 gain
  localparam int unsigned RANGE_W  = 17;  // timer period plus one
  localparam int unsigned CMP_W    = 16;  // timer compare value
  localparam int unsigned KIND_W   = 3;   // channel selector
  localparam int unsigned CFG_A_W  = 3;   // register index

  // Arithmetic widths
  localparam int unsigned DIFF_W   = 16;  // level minus center, signed
  localparam int unsigned TERM_W   = 29;  // (level - center) * gain, signed
  localparam int unsigned DUTY_W   = 30;  // rotor duty, signed Q.16 percent
  localparam int unsigned SCALED_W = 29;  // range * duty / 2^16
  localparam int unsigned RECIP_W  = 24;  // reciprocal of 100, scaled by 2^30
  localparam int unsigned SMALL_W  = 23;  // scaled value below saturation
  localparam int unsigned QUOT_W   = 17;  // scaled / 100
  localparam int unsigned MUL_A_W  = 31;
  localparam int unsigned MUL_B_W  = 25;
  localparam int unsigned MUL_P_W  = MUL_A_W + MUL_B_W;

  // Level constants, Q7.8 percent
  localparam logic [LEVEL_W-1:0] LEVEL_CENTER = 15'd12800;  // 50%
  localparam logic [LEVEL_W-1:0] LEVEL_FULL   = 15'd25600;  // 100%
  localparam logic [LEVEL_W-1:0] LEVEL_MIN_ON = 15'd256;    // 1%

  // Divide by 100 as multiply by ceil(2^30 / 100) and shift by 30; exact
  // for every value below SAT_LIMIT
  localparam logic [RECIP_W-1:0]  RECIP_100 = 24'd10737419;
  localparam int unsigned         RECIP_SH  = 30;
  // Scaled values at or above 100 * 65537 always saturate the compare
  localparam logic [SCALED_W-1:0] SAT_LIMIT = 29'd6553700;
  localparam logic [CMP_W-1:0]    CMP_MAX   = 16'hFFFF;

  // Channel codes
  localparam logic [KIND_W-1:0] REQ_NONE      = 3'd0;
  localparam logic [KIND_W-1:0] REQ_PITCH     = 3'd1;
  localparam logic [KIND_W-1:0] REQ_ROLL      = 3'd2;
  localparam logic [KIND_W-1:0] REQ_THROTTLE  = 3'd3;
  localparam logic [KIND_W-1:0] REQ_YAW       = 3'd4;
  localparam logic [KIND_W-1:0] REQ_AUTOPILOT = 3'd5;

  // Register indexes
  localparam logic [CFG_A_W-1:0] CFG_THROTTLE_OFFSET = 3'd0;
  localparam logic [CFG_A_W-1:0] CFG_PITCH_GAIN      = 3'd1;
  localparam logic [CFG_A_W-1:0] CFG_ROLL_GAIN       = 3'd2;
  localparam logic [CFG_A_W-1:0] CFG_YAW_GAIN        = 3'd3;
  localparam logic [CFG_A_W-1:0] CFG_COUNTER_RANGE   = 3'd4;

  // Request to the shared multiplier
  typedef struct packed {
    logic                       load;
    logic signed [MUL_A_W-1:0]  a;
    logic signed [MUL_B_W-1:0]  b;
  } mul_req_t;

endpackage

[src/qrmm_mul.sv]
// ----------------------------------------------------------------------------
// qrmm_mul
// Shared signed multiplier with a registered product. The product updates
// only on a load request and holds otherwise.
// ----------------------------------------------------------------------------
module qrmm_mul (
  input  logic                                  clk,
  input  qrmm_pkg::mul_req_t                    req_i,
  output logic signed [qrmm_pkg::MUL_P_W-1:0]   prod_o
);
  import qrmm_pkg::*;

  logic signed [MUL_P_W-1:0] prod_r;
  logic signed [MUL_P_W-1:0] prod_nxt;

  // Multiply at full product width
  always_comb begin
    prod_nxt = MUL_P_W'(req_i.a) * MUL_P_W'(req_i.b);
  end

  // Hold the product until the next request
  always_ff @(posedge clk) begin
    if (req_i.load) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod_o = prod_r;

endmodule

[src/quad_rotor_motor_mixer.sv]
// ----------------------------------------------------------------------------
// quad_rotor_motor_mixer
// X-frame quadcopter mixer: stick channel update, four rotor mix and timer
// compare scaling on one shared multiplier.
// ----------------------------------------------------------------------------
// Each input word updates one stick channel (in_tuser: 1 pitch, 2 roll,
// 3 throttle, 4 yaw; other codes update nothing) and yields one output word
// with the four rotor timer compares and the motors-active flag. A new item
// is accepted only after the current one has loaded its result, which waits
// until the previous word is taken; a finished word may wait in the output
// register while the next item is accepted. Each item runs on the single
// 31x25 multiplier, used three times for the stick terms and twice per rotor
// (range scaling, then divide by 100 via a reciprocal), under a short
// sequencer. Compares read zero and motors_active is low while throttle is
// below 1%. Write configuration only while idle.
// ----------------------------------------------------------------------------
module quad_rotor_motor_mixer (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [15:0]                       in_tdata,   // [14:0] duty_value
  input  logic [qrmm_pkg::KIND_W-1:0]       in_tuser,   // [2:0] req_type
  // Result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] front_left_compare, [31:16] front_right_compare,
  // [47:32] rear_left_compare, [63:48] rear_right_compare, [64] motors_active
  output logic [71:0]                       out_tdata,
  // Configuration port
  input  logic                              cfg_we,
  input  logic [qrmm_pkg::CFG_A_W-1:0]      cfg_addr,
  input  logic [qrmm_pkg::RANGE_W-1:0]      cfg_wdata
);
  import qrmm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TERM_P,
    ST_TERM_R,
    ST_TERM_Y,
    ST_TERM_CAP,
    ST_SUM,
    ST_SCALE,
    ST_RECIP,
    ST_CLAMP,
    ST_DONE
  } state_t;

  // Configuration
  logic [LEVEL_W-1:0]  offset_r;
  logic [GAIN_W-1:0]   pitch_gain_r;
  logic [GAIN_W-1:0]   roll_gain_r;
  logic [GAIN_W-1:0]   yaw_gain_r;
  logic [RANGE_W-1:0]  range_r;

  // Channel levels
  logic [LEVEL_W-1:0]  pitch_r;
  logic [LEVEL_W-1:0]  roll_r;
  logic [LEVEL_W-1:0]  yaw_r;
  logic [LEVEL_W-1:0]  throttle_r;

  // Sequencer and datapath
  state_t                     state_r;
  logic [1:0]                 rot_r;
  logic signed [TERM_W-1:0]   pterm_r;
  logic signed [TERM_W-1:0]   rterm_r;
  logic signed [TERM_W-1:0]   yterm_r;
  logic signed [DUTY_W-1:0]   duty_r;
  logic                       nonpos_r;
  logic                       sat_r;
  logic [CMP_W-1:0]           cmp_r [4];
  logic                       out_tvalid_r;
  logic [71:0]                out_tdata_r;

  logic [LEVEL_W-1:0]         in_duty;
  logic [LEVEL_W-1:0]         throttle_nxt;
  logic [LEVEL_W-1:0]         thr_diff;
  logic signed [DIFF_W-1:0]   pitch_diff;
  logic signed [DIFF_W-1:0]   roll_diff;
  logic signed [DIFF_W-1:0]   yaw_diff;
  logic signed [DUTY_W-1:0]   t_term;
  logic signed [DUTY_W-1:0]   p_sel;
  logic signed [DUTY_W-1:0]   r_sel;
  logic signed [DUTY_W-1:0]   y_sel;
  logic signed [DUTY_W-1:0]   duty_nxt;
  logic [SCALED_W-1:0]        scaled;
  logic [QUOT_W-1:0]          quot;
  logic [QUOT_W-1:0]          quot_m1;
  logic [RANGE_W-1:0]         range_m1;
  logic [CMP_W-1:0]           top;
  logic [CMP_W-1:0]           cmp_nxt;
  logic                       active;
  logic                       in_fire;
  logic                       out_load;

  mul_req_t                   mul_req;
  logic signed [MUL_P_W-1:0]  prod;

  qrmm_mul u_mul (
    .clk    (clk),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign in_duty    = in_tdata[LEVEL_W-1:0];
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_load   = (state_r == ST_DONE) && (!out_tvalid_r || out_tready);

  // Subtract the offset and clamp throttle to 0..100%
  always_comb begin
    thr_diff = in_duty - offset_r;
    if (in_duty <= offset_r) begin
      throttle_nxt = '0;
    end else if (thr_diff > LEVEL_FULL) begin
      throttle_nxt = LEVEL_FULL;
    end else begin
      throttle_nxt = thr_diff;
    end
  end

  // Center the stick levels
  assign pitch_diff = $signed({1'b0, pitch_r}) - $signed({1'b0, LEVEL_CENTER});
  assign roll_diff  = $signed({1'b0, roll_r})  - $signed({1'b0, LEVEL_CENTER});
  assign yaw_diff   = $signed({1'b0, yaw_r})   - $signed({1'b0, LEVEL_CENTER});

  // Drive the shared multiplier from the current step
  always_comb begin
    mul_req = '0;
    case (state_r)
      ST_TERM_P: begin
        mul_req.load = 1'b1;
        mul_req.a    = MUL_A_W'(pitch_diff);
        mul_req.b    = $signed(MUL_B_W'(pitch_gain_r));
      end
      ST_TERM_R: begin
        mul_req.load = 1'b1;
        mul_req.a    = MUL_A_W'(roll_diff);
        mul_req.b    = $signed(MUL_B_W'(roll_gain_r));
      end
      ST_TERM_Y: begin
        mul_req.load = 1'b1;
        mul_req.a    = MUL_A_W'(yaw_diff);
        mul_req.b    = $signed(MUL_B_W'(yaw_gain_r));
      end
      ST_SCALE: begin
        mul_req.load = 1'b1;
        mul_req.a    = MUL_A_W'(duty_r);
        mul_req.b    = $signed(MUL_B_W'(range_r));
      end
      ST_RECIP: begin
        mul_req.load = 1'b1;
        mul_req.a    = $signed(MUL_A_W'(scaled[SMALL_W-1:0]));
        mul_req.b    = $signed(MUL_B_W'(RECIP_100));
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  // Mix one rotor: signs of yaw, roll and pitch per X-frame position
  always_comb begin
    t_term = $signed(DUTY_W'({throttle_r, 8'd0}));
    p_sel  = DUTY_W'(pterm_r);
    r_sel  = DUTY_W'(rterm_r);
    y_sel  = DUTY_W'(yterm_r);
    case (rot_r)
      2'd0: duty_nxt = t_term - y_sel + r_sel - p_sel;  // front left
      2'd1: duty_nxt = t_term + y_sel - r_sel - p_sel;  // front right
      2'd2: duty_nxt = t_term + y_sel + r_sel + p_sel;  // rear left
      2'd3: duty_nxt = t_term - y_sel - r_sel + p_sel;  // rear right
      default: duty_nxt = t_term;
    endcase
  end

  // Range times duty, dropped by 2^16; then quotient by 100
  assign scaled  = prod[SCALED_W+15:16];
  assign quot    = prod[RECIP_SH+QUOT_W-1:RECIP_SH];
  assign quot_m1 = quot - QUOT_W'(1);

  // Compare ceiling: range - 1, capped at the timer maximum
  always_comb begin
    range_m1 = range_r - RANGE_W'(1);
    if (range_m1 > RANGE_W'(CMP_MAX)) begin
      top = CMP_MAX;
    end else begin
      top = range_m1[CMP_W-1:0];
    end
  end

  // Saturate the compare; the quotient is only valid below the saturation limit
  always_comb begin
    if (nonpos_r) begin
      cmp_nxt = '0;
    end else if (sat_r) begin
      cmp_nxt = top;
    end else if (quot == '0) begin
      cmp_nxt = '0;
    end else if (quot_m1 > QUOT_W'(top)) begin
      cmp_nxt = top;
    end else begin
      cmp_nxt = quot_m1[CMP_W-1:0];
    end
  end

  assign active = (throttle_r >= LEVEL_MIN_ON);

  // Sequencer, levels, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rot_r        <= '0;
      out_tvalid_r <= 1'b0;
      offset_r     <= '0;
      pitch_gain_r <= GAIN_W'(256);
      roll_gain_r  <= GAIN_W'(256);
      yaw_gain_r   <= GAIN_W'(256);
      range_r      <= RANGE_W'(1000);
      pitch_r      <= LEVEL_CENTER;
      roll_r       <= LEVEL_CENTER;
      yaw_r        <= LEVEL_CENTER;
      throttle_r   <= '0;
    end else begin
      // Take register writes
      if (cfg_we) begin
        case (cfg_addr)
          CFG_THROTTLE_OFFSET: offset_r     <= cfg_wdata[LEVEL_W-1:0];
          CFG_PITCH_GAIN:      pitch_gain_r <= cfg_wdata[GAIN_W-1:0];
          CFG_ROLL_GAIN:       roll_gain_r  <= cfg_wdata[GAIN_W-1:0];
          CFG_YAW_GAIN:        yaw_gain_r   <= cfg_wdata[GAIN_W-1:0];
          CFG_COUNTER_RANGE:   range_r      <= cfg_wdata;
          default: ;
        endcase
      end

      // Drop the output word once taken, unless a new one replaces it
      if (out_tvalid_r && out_tready && !out_load) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_tuser)
              REQ_PITCH:    pitch_r    <= in_duty;
              REQ_ROLL:     roll_r     <= in_duty;
              REQ_THROTTLE: throttle_r <= throttle_nxt;
              REQ_YAW:      yaw_r      <= in_duty;
              default: ;
            endcase
            rot_r   <= '0;
            state_r <= ST_TERM_P;
          end
        end
        ST_TERM_P: state_r <= ST_TERM_R;
        ST_TERM_R: begin
          pterm_r <= prod[TERM_W-1:0];
          state_r <= ST_TERM_Y;
        end
        ST_TERM_Y: begin
          rterm_r <= prod[TERM_W-1:0];
          state_r <= ST_TERM_CAP;
        end
        ST_TERM_CAP: begin
          yterm_r <= prod[TERM_W-1:0];
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          duty_r   <= duty_nxt;
          nonpos_r <= (duty_nxt <= 0);
          state_r  <= ST_SCALE;
        end
        ST_SCALE: state_r <= ST_RECIP;
        ST_RECIP: begin
          sat_r   <= (scaled >= SAT_LIMIT);
          state_r <= ST_CLAMP;
        end
        ST_CLAMP: begin
          cmp_r[rot_r] <= cmp_nxt;
          if (rot_r == 2'd3) begin
            state_r <= ST_DONE;
          end else begin
            rot_r   <= rot_r + 2'd1;
            state_r <= ST_SUM;
          end
        end
        ST_DONE: begin
          // Load the output word, zeroed while motors are off
          if (out_load) begin
            out_tvalid_r       <= 1'b1;
            out_tdata_r[71:65] <= '0;
            out_tdata_r[64]    <= active;
            out_tdata_r[15:0]  <= active ? cmp_r[0] : '0;
            out_tdata_r[31:16] <= active ? cmp_r[1] : '0;
            out_tdata_r[47:32] <= active ? cmp_r[2] : '0;
            out_tdata_r[63:48] <= active ? cmp_r[3] : '0;
            state_r            <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // Busy after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while mixer busy");

  // Motors off means all compares zero
  a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[64] |-> out_tdata[63:0] == 64'd0)
    else $error("nonzero compare with motors off");

  // Compares never exceed the timer period
  a_under_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (range_r != '0) |->
      (RANGE_W'(out_tdata[15:0])  <= range_r - RANGE_W'(1)) &&
      (RANGE_W'(out_tdata[31:16]) <= range_r - RANGE_W'(1)) &&
      (RANGE_W'(out_tdata[47:32]) <= range_r - RANGE_W'(1)) &&
      (RANGE_W'(out_tdata[63:48]) <= range_r - RANGE_W'(1)))
    else $error("compare above timer period");

  // A finished item reaches the output when it is free
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && out_tready |=> out_tvalid && in_tready)
    else $error("finished item not presented");
`endif

endmodule
